### rtl/core/epc_pkg.sv
// epc_pkg: shared types, constants and calendar helpers for epoch_to_calendar
// used by epc_cfg, epc_seq and epoch_to_calendar; depends on nothing
`timescale 1ns / 1ps

package epc_pkg;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_WEEK  = 7;
  localparam int unsigned EPOCH_WEEKDAY  = 4;
  localparam int unsigned BASE_YEAR_OFS  = 70;
  localparam int unsigned DAY_STEPS      = 17;
  localparam int unsigned HOUR_BITS      = 5;
  localparam int unsigned MIN_BITS       = 6;
  localparam int unsigned WDAY_STEPS     = 14;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  localparam logic REG_ZONE = 1'b0;
  localparam logic REG_DST  = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADJ,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [7:0] year_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [4:0] daylight_value;
    logic       clamped;
  } res_t;

  typedef struct packed {
    logic signed [16:0] zone_offset_seconds;
    logic        [4:0]  daylight_hours;
  } cfg_t;

  // years 1970..2106 as offsets from 1900; 2000 is leap, 2100 is not
  function automatic logic is_leap(input logic [7:0] yr);
    return (yr[1:0] == 2'b00) && (yr != 8'd200);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] yr);
    return 9'd365 + {8'd0, is_leap(yr)};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic lp);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = lp ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/epc_cfg.sv
// epc_cfg: apb register file holding zone offset and daylight hours
// depends on epc_pkg
`timescale 1ns / 1ps

module epc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epc_pkg::PADDR_W-1:0]   paddr,
  input  logic [epc_pkg::PDATA_W-1:0]   pwdata,
  output logic [epc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output epc_pkg::cfg_t                 cfg
);
  import epc_pkg::*;

  logic signed [16:0] zone_r, zone_nxt;
  logic        [4:0]  dst_r, dst_nxt;
  logic               wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    zone_nxt = zone_r;
    dst_nxt  = dst_r;
    if (wr_en) begin
      case (paddr[2])
        REG_ZONE: zone_nxt = pwdata[16:0];
        REG_DST:  dst_nxt  = pwdata[4:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
      dst_r  <= '0;
    end else begin
      zone_r <= zone_nxt;
      dst_r  <= dst_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ZONE: prdata = {{(PDATA_W-17){zone_r[16]}}, zone_r};
      REG_DST:  prdata = {{(PDATA_W-5){1'b0}}, dst_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.zone_offset_seconds = zone_r;
  assign cfg.daylight_hours      = dst_r;

endmodule

### rtl/core/epc_sub.sv
// epc_sub: shared 18-bit compare and subtract unit
// depends on nothing
`timescale 1ns / 1ps

module epc_sub (
  input  logic [17:0] a,
  input  logic [17:0] b,
  output logic [17:0] diff,
  output logic        ge
);

  logic [18:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[17:0];
  assign ge   = !full[18];

endmodule

### rtl/core/epc_seq.sv
// epc_seq: sequencer and working registers for the date conversion
// depends on epc_pkg and epc_sub
`timescale 1ns / 1ps

module epc_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           ready,
  input  logic [31:0]    epoch,
  input  epc_pkg::cfg_t  cfg,
  output logic           res_valid,
  input  logic           res_take,
  output epc_pkg::res_t  res
);
  import epc_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] epoch_r, epoch_nxt;
  logic [16:0] num_r, num_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] wk_r, wk_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [8:0]  yday_r, yday_nxt;
  logic        clamp_r, clamp_nxt;

  logic [16:0] dst_secs;
  logic [34:0] adj;
  logic [32:0] t_adj;
  logic [17:0] sub_a, sub_b, sub_diff;
  logic        sub_ge;

  epc_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  assign dst_secs = 17'(cfg.daylight_hours) * 17'(SECS_PER_HOUR);
  assign adj      = {3'b000, epoch_r}
                  - {{18{cfg.zone_offset_seconds[16]}}, cfg.zone_offset_seconds}
                  + {18'd0, dst_secs};
  assign t_adj    = adj[34] ? '0 : adj[32:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    epoch_nxt = epoch_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    wk_nxt    = wk_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    yday_nxt  = yday_r;
    clamp_nxt = clamp_r;
    sub_a     = '0;
    sub_b     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          epoch_nxt = epoch;
          state_nxt = ST_ADJ;
        end
      end
      ST_ADJ: begin
        clamp_nxt = adj[34];
        rem_nxt   = {1'b0, t_adj[32:17]};
        num_nxt   = t_adj[16:0];
        cnt_nxt   = 5'(DAY_STEPS - 1);
        state_nxt = ST_DAYS;
      end
      ST_DAYS: begin
        sub_a   = {rem_r, num_r[16]};
        sub_b   = 18'(SECS_PER_DAY);
        rem_nxt = sub_ge ? sub_diff[16:0] : sub_a[16:0];
        quo_nxt = {quo_r[14:0], sub_ge};
        num_nxt = {num_r[15:0], 1'b0};
        if (cnt_r == '0) begin
          cnt_nxt   = 5'(HOUR_BITS - 1);
          state_nxt = ST_HOUR;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_HOUR: begin
        sub_a    = {1'b0, rem_r};
        sub_b    = 18'(SECS_PER_HOUR) << cnt_r;
        rem_nxt  = sub_ge ? sub_diff[16:0] : rem_r;
        hour_nxt = {hour_r[3:0], sub_ge};
        if (cnt_r == '0) begin
          cnt_nxt   = 5'(MIN_BITS - 1);
          state_nxt = ST_MIN;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_MIN: begin
        sub_a   = {1'b0, rem_r};
        sub_b   = 18'(SECS_PER_MIN) << cnt_r;
        rem_nxt = sub_ge ? sub_diff[16:0] : rem_r;
        min_nxt = {min_r[4:0], sub_ge};
        if (cnt_r == '0) begin
          wk_nxt    = quo_r + 16'(EPOCH_WEEKDAY);
          cnt_nxt   = 5'(WDAY_STEPS - 1);
          state_nxt = ST_WDAY;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_WDAY: begin
        sub_a  = {2'b00, wk_r};
        sub_b  = 18'(DAYS_PER_WEEK) << cnt_r;
        wk_nxt = sub_ge ? sub_diff[15:0] : wk_r;
        if (cnt_r == '0) begin
          year_nxt  = 8'(BASE_YEAR_OFS);
          state_nxt = ST_YEAR;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_YEAR: begin
        sub_a = {2'b00, quo_r};
        sub_b = {9'd0, year_len(year_r)};
        if (sub_ge) begin
          quo_nxt  = sub_diff[15:0];
          year_nxt = year_r + 8'd1;
        end else begin
          yday_nxt  = quo_r[8:0];
          month_nxt = MONTH_JAN;
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        sub_a = {2'b00, quo_r};
        sub_b = {13'd0, month_len(month_r, is_leap(year_r))};
        if (!sub_ge || month_r == MONTH_DEC) begin
          state_nxt = ST_DONE;
        end else begin
          quo_nxt   = sub_diff[15:0];
          month_nxt = month_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    epoch_r <= epoch_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    wk_r    <= wk_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    yday_r  <= yday_nxt;
    clamp_r <= clamp_nxt;
  end

  assign ready     = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  assign res.year_since_1900  = year_r;
  assign res.month_index      = month_r;
  assign res.day_of_month     = quo_r[4:0] + 5'd1;
  assign res.hour_of_day      = hour_r;
  assign res.minute_of_hour   = min_r;
  assign res.second_of_minute = rem_r[5:0];
  assign res.weekday          = wk_r[2:0];
  assign res.day_of_year      = yday_r;
  assign res.daylight_value   = cfg.daylight_hours;
  assign res.clamped          = clamp_r;

endmodule

### rtl/core/epoch_to_calendar.sv
// epoch_to_calendar: top level, unix seconds to civil date and time of day
// depends on epc_pkg, epc_cfg, epc_seq and epc_sub
`timescale 1ns / 1ps

// each transaction runs through sequencer steps that all share one 18-bit subtract unit:
// the zone and daylight adjust, 17 steps for days and seconds of day, 5 and 6 steps
// for hour and minute, 14 steps for the weekday, one step per year and one per month
// plus a closing step for each loop, then the hand-off of the result to the output
// register; the input stalls until the result moves to the output register, so a new
// transaction is taken while the previous result waits there; adjusted times below
// zero give 1970-01-01 00:00:00 with clamped set

module epoch_to_calendar (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_epoch_seconds,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_year_since_1900,
  output logic [3:0]                    out_month_index,
  output logic [4:0]                    out_day_of_month,
  output logic [4:0]                    out_hour_of_day,
  output logic [5:0]                    out_minute_of_hour,
  output logic [5:0]                    out_second_of_minute,
  output logic [2:0]                    out_weekday,
  output logic [8:0]                    out_day_of_year,
  output logic [4:0]                    out_daylight_value,
  output logic                          out_clamped,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [epc_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [epc_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [epc_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import epc_pkg::*;

  cfg_t cfg;
  res_t seq_res;
  res_t out_res_r, out_res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic seq_ready, seq_res_valid, res_take;

  epc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  epc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && seq_ready),
    .ready     (seq_ready),
    .epoch     (in_epoch_seconds),
    .cfg       (cfg),
    .res_valid (seq_res_valid),
    .res_take  (res_take),
    .res       (seq_res)
  );

  assign in_stall = !seq_ready;
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (seq_res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = seq_res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_year_since_1900  = out_res_r.year_since_1900;
  assign out_month_index      = out_res_r.month_index;
  assign out_day_of_month     = out_res_r.day_of_month;
  assign out_hour_of_day      = out_res_r.hour_of_day;
  assign out_minute_of_hour   = out_res_r.minute_of_hour;
  assign out_second_of_minute = out_res_r.second_of_minute;
  assign out_weekday          = out_res_r.weekday;
  assign out_day_of_year      = out_res_r.day_of_year;
  assign out_daylight_value   = out_res_r.daylight_value;
  assign out_clamped          = out_res_r.clamped;

endmodule

### tb/tb.sv
// tb: self-checking bench for epoch_to_calendar, unix seconds to civil date and time
// depends on epc_pkg and epoch_to_calendar; directed dates, then random stamps over config phases
`timescale 1ns / 1ps

module tb;
  import epc_pkg::*;

  localparam longint DAY_SECONDS = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 250;
  localparam logic [PADDR_W-1:0] ZONE_ADDR = {REG_ZONE, 2'b00};
  localparam logic [PADDR_W-1:0] DST_ADDR = {REG_DST, 2'b00};
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [31:0] epoch;
    int unsigned gap;
  } stamp_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_year_since_1900;
  logic [3:0] out_month_index;
  logic [4:0] out_day_of_month;
  logic [4:0] out_hour_of_day;
  logic [5:0] out_minute_of_hour;
  logic [5:0] out_second_of_minute;
  logic [2:0] out_weekday;
  logic [8:0] out_day_of_year;
  logic [4:0] out_daylight_value;
  logic out_clamped;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  stamp_item_t pending_stamps[$];
  stamp_item_t next_stamp;
  res_t expected_dates[$];
  logic signed [16:0] zone_now = '0;
  logic [4:0] dst_now = '0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_request = 1'b0;
  int unsigned gap_count = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  epoch_to_calendar u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic res_t calendar_of(logic [31:0] secs_in);
    longint adj;
    longint unsigned t, days, sod;
    int unsigned yr, mon, ylen, mlen, yday;
    res_t r;
    adj = longint'({32'd0, secs_in}) - longint'(zone_now) + longint'(HOUR_SECONDS * dst_now);
    r.clamped = (adj < 0);
    if (adj < 0) adj = 0;
    t = adj;
    days = t / DAY_SECONDS;
    sod = t % DAY_SECONDS;
    yr = 1970;
    while (1) begin
      ylen = 365 + leap_year(yr);
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    yday = 32'(days);
    mon = 0;
    while (1) begin
      mlen = MONTH_DAYS[mon] + ((mon == 1) ? leap_year(yr) : 0);
      if (days < mlen || mon == 11) break;
      days -= mlen;
      mon++;
    end
    r.year_since_1900 = 8'(yr - 1900);
    r.month_index = 4'(mon);
    r.day_of_month = 5'(days + 1);
    r.hour_of_day = 5'(sod / 3600);
    r.minute_of_hour = 6'((sod % 3600) / 60);
    r.second_of_minute = 6'(sod % 60);
    r.weekday = 3'((t / DAY_SECONDS + 4) % 7);
    r.day_of_year = 9'(yday);
    r.daylight_value = dst_now;
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_count = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_dates.push_back(calendar_of(in_epoch_seconds));
      if (pending_stamps.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_count < pending_stamps[0].gap) begin
        gap_count++;
        in_valid <= 1'b0;
      end else begin
        next_stamp = pending_stamps.pop_front();
        in_epoch_seconds <= next_stamp.epoch;
        in_valid <= 1'b1;
        gap_count = 0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          mismatches++;
          $display("%0t result transaction with nothing expected: year %0d", $time,
                   out_year_since_1900);
        end else begin
          want = expected_dates.pop_front();
          compare_field("year_since_1900", want.year_since_1900, out_year_since_1900);
          compare_field("month_index", want.month_index, out_month_index);
          compare_field("day_of_month", want.day_of_month, out_day_of_month);
          compare_field("hour_of_day", want.hour_of_day, out_hour_of_day);
          compare_field("minute_of_hour", want.minute_of_hour, out_minute_of_hour);
          compare_field("second_of_minute", want.second_of_minute, out_second_of_minute);
          compare_field("weekday", want.weekday, out_weekday);
          compare_field("day_of_year", want.day_of_year, out_day_of_year);
          compare_field("daylight_value", want.daylight_value, out_daylight_value);
          compare_field("clamped", want.clamped, out_clamped);
        end
        stall_left = rx_idle ? $urandom_range(0, 15) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_request) begin
        stall_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t no transaction for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  task automatic apb_transfer(input logic [PADDR_W-1:0] addr, input logic wr,
                              input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(logic signed [16:0] zone, logic [4:0] dst);
    logic [PDATA_W-1:0] rd;
    apb_transfer(ZONE_ADDR, 1'b1, {{15{zone[16]}}, zone}, rd);
    apb_transfer(DST_ADDR, 1'b1, {27'd0, dst}, rd);
    zone_now = zone;
    dst_now = dst;
    apb_transfer(ZONE_ADDR, 1'b0, '0, rd);
    if (rd[16:0] !== zone) begin
      mismatches++;
      $display("%0t zone readback: expected %0h, actual %0h", $time, zone, rd[16:0]);
    end
    apb_transfer(DST_ADDR, 1'b0, '0, rd);
    if (rd[4:0] !== dst) begin
      mismatches++;
      $display("%0t daylight readback: expected %0h, actual %0h", $time, dst, rd[4:0]);
    end
  endtask

  task automatic push_stamp(logic [31:0] v);
    pending_stamps.push_back('{v, tx_idle ? $urandom_range(0, 15) : 0});
  endtask

  task automatic push_random_stamps(int n);
    longint v;
    int unsigned yr;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        4, 5: begin
          // land within a day of a new year
          yr = $urandom_range(1971, 2106);
          v = 0;
          for (int unsigned y = 1970; y < yr; y++) v += (365 + leap_year(y)) * DAY_SECONDS;
          v = v + $urandom_range(0, 172800) - DAY_SECONDS;
          if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        end
        6: v = $urandom_range(0, 200000);
        7: v = 32'hFFFF_FFFF - $urandom_range(0, 40000000);
        default: v = $urandom;
      endcase
      push_stamp(v[31:0]);
    end
  endtask

  task automatic wait_drained();
    while (pending_stamps.size() != 0 || in_valid || expected_dates.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int z;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: calendar corners, leap rules, 32-bit extremes
    push_stamp(32'd0);
    push_stamp(32'd59);
    push_stamp(32'd86399);
    push_stamp(32'd86400);
    push_stamp(32'd94694399);
    push_stamp(32'd946684799);
    push_stamp(32'd946684800);
    push_stamp(32'd951782400);
    push_stamp(32'd978307199);
    push_stamp(32'd1078056000);
    push_stamp(32'd2147483647);
    push_stamp(32'd2147483648);
    push_stamp(32'd4107542399);
    push_stamp(32'd4107542400);
    push_stamp(32'hAAAA_AAAA);
    push_stamp(32'h5555_5555);
    push_stamp(32'hFFFF_FFFF);
    wait_drained();

    // largest east offset: small stamps go negative and clamp
    set_config(17'sd50400, 5'd0);
    push_stamp(32'd0);
    push_stamp(32'd50399);
    push_stamp(32'd50400);
    push_stamp(32'd50401);
    push_stamp(32'hFFFF_FFFF);
    push_random_stamps(140);
    wait_drained();

    set_config(-17'sd50400, 5'd23);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    push_random_stamps(150);
    wait_drained();

    // register extremes; receiver holds off so the input backs up
    set_config(-17'sd65536, 5'd31);
    rx_idle = 1'b1;
    push_stamp(32'hFFFF_FFFF);
    push_stamp(32'd0);
    push_random_stamps(150);
    hold_request = 1'b1;
    wait_drained();

    set_config(17'sd65535, 5'd0);
    push_random_stamps(150);
    wait_drained();

    set_config(17'sd0, 5'd0);
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    push_random_stamps(150);
    wait_drained();

    for (int k = 0; k < 3; k++) begin
      z = int'($urandom_range(0, 100800)) - 50400;
      set_config(17'(z), 5'($urandom_range(0, 23)));
      tx_idle = $urandom_range(0, 1);
      rx_idle = $urandom_range(0, 1);
      push_random_stamps(100);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
